/* sv/pool_free_list_mark_sweep_top_macros.svh */
// ---------------------------------------------------------------------------
// pool free list assertion macros
// shared concurrent assertion forms, clocked on clk and held off by rst
// ---------------------------------------------------------------------------
`ifndef POOL_FREE_LIST_MARK_SWEEP_TOP_MACROS_SVH
`define POOL_FREE_LIST_MARK_SWEEP_TOP_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define PFLMS_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// consequent must hold in the cycle after the antecedent
`define PFLMS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

/* sv/pflms_pkg.sv */
// ---------------------------------------------------------------------------
// pool free list package
// opcodes, slot marks and the structs shared by the sequencer, the store
// and the top level
// ---------------------------------------------------------------------------
package pflms_pkg;

  // default number of slots in the pool
  localparam int unsigned POOL_DEPTH_DEF = 256;

  // item opcodes; code 7 is unused and returns an all-zero result
  typedef enum logic [2:0] {
    OP_INIT          = 3'd0,
    OP_ALLOC         = 3'd1,
    OP_FREE          = 3'd2,
    OP_BEGIN_COLLECT = 3'd3,
    OP_MARK_LIVE     = 3'd4,
    OP_SWEEP         = 3'd5,
    OP_READ_STATUS   = 3'd6
  } op_t;

  // slot marks
  localparam logic [1:0] MARK_EMPTY   = 2'd0;
  localparam logic [1:0] MARK_LIVE    = 2'd1;
  localparam logic [1:0] MARK_GARBAGE = 2'd2;

  // memory strobes from the sequencer to the store
  typedef struct packed {
    logic link_we;
    logic link_re;
    logic mark_we;
    logic mark_re;
  } mem_ctl_t;

  // one result item
  typedef struct packed {
    logic [8:0] reclaimed_count;
    logic [1:0] entry_status;
    logic [7:0] granted_slot;
    logic       result_code;
  } res_t;

endpackage

/* sv/pflms_store.sv */
// ---------------------------------------------------------------------------
// pool free list store
// link memory and mark memory, one write and one registered read each
// ---------------------------------------------------------------------------
module pflms_store #(
  parameter int unsigned POOL_DEPTH = pflms_pkg::POOL_DEPTH_DEF,
  localparam int unsigned AW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1,
  localparam int unsigned LW = $clog2(POOL_DEPTH + 1)
) (
  input  logic                 clk,
  input  pflms_pkg::mem_ctl_t  mem_ctl,
  input  logic [AW-1:0]        link_waddr,
  input  logic [LW-1:0]        link_wdata,
  input  logic [AW-1:0]        link_raddr,
  output logic [LW-1:0]        link_rdata,
  input  logic [AW-1:0]        mark_waddr,
  input  logic [1:0]           mark_wdata,
  input  logic [AW-1:0]        mark_raddr,
  output logic [1:0]           mark_rdata
);

  logic [LW-1:0] link_mem [POOL_DEPTH];
  logic [1:0]    mark_mem [POOL_DEPTH];

  // next-slot links, read data held until the next read
  always_ff @(posedge clk) begin
    if (mem_ctl.link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    if (mem_ctl.link_re) begin
      link_rdata <= link_mem[link_raddr];
    end
  end

  // per-slot marks
  always_ff @(posedge clk) begin
    if (mem_ctl.mark_we) begin
      mark_mem[mark_waddr] <= mark_wdata;
    end
    if (mem_ctl.mark_re) begin
      mark_rdata <= mark_mem[mark_raddr];
    end
  end

endmodule

/* sv/pflms_seq.sv */
// ---------------------------------------------------------------------------
// pool free list sequencer
// decodes each item, drives the store and walks the pool for the long ops
// ---------------------------------------------------------------------------
module pflms_seq #(
  parameter int unsigned POOL_DEPTH = pflms_pkg::POOL_DEPTH_DEF,
  localparam int unsigned AW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1,
  localparam int unsigned LW = $clog2(POOL_DEPTH + 1),
  localparam int unsigned CW = $clog2(POOL_DEPTH + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [2:0]           in_opcode,
  input  logic [7:0]           in_slot,
  output logic                 res_valid,
  input  logic                 res_ready,
  output pflms_pkg::res_t      res,
  output pflms_pkg::mem_ctl_t  mem_ctl,
  output logic [AW-1:0]        link_waddr,
  output logic [LW-1:0]        link_wdata,
  output logic [AW-1:0]        link_raddr,
  input  logic [LW-1:0]        link_rdata,
  output logic [AW-1:0]        mark_waddr,
  output logic [1:0]           mark_wdata,
  output logic [AW-1:0]        mark_raddr,
  input  logic [1:0]           mark_rdata
);

  typedef enum logic [7:0] {
    ST_CLEAR   = 8'b0000_0001,
    ST_IDLE    = 8'b0000_0010,
    ST_INIT    = 8'b0000_0100,
    ST_GARB    = 8'b0000_1000,
    ST_WALK_RD = 8'b0001_0000,
    ST_WALK_WB = 8'b0010_0000,
    ST_SWEEP   = 8'b0100_0000,
    ST_FIN     = 8'b1000_0000
  } state_t;

  localparam logic [LW-1:0] LINK_NULL = LW'(POOL_DEPTH);
  localparam logic [CW-1:0] IDX_LAST  = CW'(POOL_DEPTH - 1);
  localparam logic [CW-1:0] IDX_END   = CW'(POOL_DEPTH);

  state_t            state;
  state_t            state_next;
  logic [CW-1:0]     idx;
  logic [CW-1:0]     wcnt;
  logic [LW-1:0]     walk_ptr;
  logic [LW-1:0]     head;
  logic [CW-1:0]     cnt;
  pflms_pkg::op_t    op_q;
  logic              slot_ok_q;
  logic              s_valid;
  logic [AW-1:0]     s_idx;

  logic              accept;
  logic              in_slot_ok;
  logic [AW-1:0]     in_slot_a;
  logic              head_null;
  logic              idx_last;
  logic              walk_end;
  logic              sweep_hit;
  logic              fin_go;

  // handshake and common decodes
  assign in_ready   = (state == ST_IDLE);
  assign accept     = in_valid && in_ready;
  assign in_slot_ok = (32'(in_slot) < 32'(POOL_DEPTH));
  assign in_slot_a  = AW'(in_slot);
  assign head_null  = (head >= LINK_NULL);
  assign idx_last   = (idx == IDX_LAST);
  assign walk_end   = (walk_ptr >= LINK_NULL) || (wcnt == IDX_END);
  assign sweep_hit  = s_valid && (mark_rdata == pflms_pkg::MARK_GARBAGE);
  assign res_valid  = (state == ST_FIN);
  assign fin_go     = res_valid && res_ready;

  // result fields, zero where the opcode does not use them
  always_comb begin
    res = '0;
    case (op_q)
      pflms_pkg::OP_ALLOC: begin
        res.result_code  = head_null;
        res.granted_slot = head_null ? 8'd0 : 8'(head);
      end
      pflms_pkg::OP_READ_STATUS: begin
        res.entry_status = slot_ok_q ? mark_rdata : pflms_pkg::MARK_EMPTY;
      end
      pflms_pkg::OP_SWEEP: begin
        res.reclaimed_count = 9'(cnt);
      end
      default: begin
        res = '0;
      end
    endcase
  end

  // memory strobes and addresses
  always_comb begin
    mem_ctl    = '0;
    link_waddr = idx[AW-1:0];
    link_wdata = head;
    link_raddr = head[AW-1:0];
    mark_waddr = idx[AW-1:0];
    mark_wdata = pflms_pkg::MARK_EMPTY;
    mark_raddr = in_slot_a;
    case (state)
      ST_CLEAR: begin
        mem_ctl.mark_we = 1'b1;
      end
      ST_IDLE: begin
        if (accept) begin
          case (pflms_pkg::op_t'(in_opcode))
            pflms_pkg::OP_ALLOC: begin
              mem_ctl.link_re = 1'b1;
            end
            pflms_pkg::OP_FREE: begin
              mem_ctl.link_we = in_slot_ok;
              mem_ctl.mark_we = in_slot_ok;
              link_waddr      = in_slot_a;
              mark_waddr      = in_slot_a;
            end
            pflms_pkg::OP_MARK_LIVE: begin
              mem_ctl.mark_we = in_slot_ok;
              mark_waddr      = in_slot_a;
              mark_wdata      = pflms_pkg::MARK_LIVE;
            end
            pflms_pkg::OP_READ_STATUS: begin
              mem_ctl.mark_re = 1'b1;
            end
            default: begin
              mem_ctl = '0;
            end
          endcase
        end
      end
      ST_INIT: begin
        mem_ctl.link_we = 1'b1;
        mem_ctl.mark_we = 1'b1;
        link_wdata      = idx_last ? LINK_NULL : LW'(idx + 1'b1);
      end
      ST_GARB: begin
        mem_ctl.mark_we = 1'b1;
        mark_wdata      = pflms_pkg::MARK_GARBAGE;
      end
      ST_WALK_RD: begin
        mem_ctl.mark_we = !walk_end;
        mem_ctl.link_re = !walk_end;
        mark_waddr      = walk_ptr[AW-1:0];
        link_raddr      = walk_ptr[AW-1:0];
      end
      ST_SWEEP: begin
        // read the next mark while the previous one is judged
        mem_ctl.mark_re = (idx != IDX_END);
        mark_raddr      = idx[AW-1:0];
        mem_ctl.link_we = sweep_hit;
        link_waddr      = s_idx;
      end
      ST_FIN: begin
        mem_ctl.mark_we = fin_go && (op_q == pflms_pkg::OP_ALLOC) && !head_null;
        mark_waddr      = head[AW-1:0];
        mark_wdata      = pflms_pkg::MARK_LIVE;
      end
      default: begin
        mem_ctl = '0;
      end
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (idx_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          case (pflms_pkg::op_t'(in_opcode))
            pflms_pkg::OP_INIT:          state_next = ST_INIT;
            pflms_pkg::OP_BEGIN_COLLECT: state_next = ST_GARB;
            pflms_pkg::OP_SWEEP:         state_next = ST_SWEEP;
            default:                     state_next = ST_FIN;
          endcase
        end
      end
      ST_INIT: begin
        if (idx_last) state_next = ST_FIN;
      end
      ST_GARB: begin
        if (idx_last) state_next = ST_WALK_RD;
      end
      ST_WALK_RD: begin
        state_next = walk_end ? ST_FIN : ST_WALK_WB;
      end
      ST_WALK_WB: begin
        state_next = ST_WALK_RD;
      end
      ST_SWEEP: begin
        if (idx == IDX_END) state_next = ST_FIN;
      end
      ST_FIN: begin
        if (res_ready) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      idx     <= '0;
      head    <= LINK_NULL;
      s_valid <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        ST_CLEAR: begin
          idx <= idx_last ? '0 : idx + 1'b1;
        end
        ST_IDLE: begin
          idx     <= '0;
          s_valid <= 1'b0;
          if (accept && (pflms_pkg::op_t'(in_opcode) == pflms_pkg::OP_FREE) && in_slot_ok) begin
            head <= LW'(in_slot);
          end
        end
        ST_INIT: begin
          idx <= idx + 1'b1;
          if (idx_last) head <= '0;
        end
        ST_GARB: begin
          idx <= idx + 1'b1;
        end
        ST_SWEEP: begin
          s_valid <= (idx != IDX_END);
          if (idx != IDX_END) idx <= idx + 1'b1;
          if (sweep_hit) head <= LW'(s_idx);
        end
        ST_FIN: begin
          if (fin_go && (op_q == pflms_pkg::OP_ALLOC) && !head_null) begin
            head <= link_rdata;
          end
        end
        default: begin
          idx <= idx;
        end
      endcase
    end
  end

  // per-item working registers
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q      <= pflms_pkg::op_t'(in_opcode);
      slot_ok_q <= in_slot_ok;
      cnt       <= '0;
    end
    if ((state == ST_GARB) && idx_last) begin
      walk_ptr <= head;
      wcnt     <= '0;
    end
    if ((state == ST_WALK_RD) && !walk_end) begin
      wcnt <= wcnt + 1'b1;
    end
    if (state == ST_WALK_WB) begin
      walk_ptr <= link_rdata;
    end
    if (state == ST_SWEEP) begin
      s_idx <= idx[AW-1:0];
      if (sweep_hit) cnt <= cnt + 1'b1;
    end
  end

endmodule

/* sv/pool_free_list_mark_sweep_top.sv */
// alloc, free, mark_live, read_status: from idle straight to the fin state, then the output register
// init writes the link and mark of every slot; sweep reads one mark per cycle
// begin_collect: marks every slot garbage, then walks the free list, a read and a write-back state per link
// one item at a time; the next is taken once the result is in the output register
// after rst, a pass over every slot clears the marks with s_tready held low
// ---------------------------------------------------------------------------
// pool free list with mark and sweep
// slot allocator over a linked free list in memory, with per-slot marks
// ---------------------------------------------------------------------------
module pool_free_list_mark_sweep_top #(
  parameter int unsigned POOL_DEPTH = pflms_pkg::POOL_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,  // opcode[2:0], slot[10:3], zero [15:11]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata   // result_code[0], granted_slot[8:1],
                                // entry_status[10:9], reclaimed_count[19:11],
                                // zero [23:20]
);

  localparam int unsigned AW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int unsigned LW = $clog2(POOL_DEPTH + 1);

  pflms_pkg::mem_ctl_t mem_ctl;
  pflms_pkg::res_t     res;
  logic                res_valid;
  logic                res_ready;
  logic [AW-1:0]       link_waddr;
  logic [LW-1:0]       link_wdata;
  logic [AW-1:0]       link_raddr;
  logic [LW-1:0]       link_rdata;
  logic [AW-1:0]       mark_waddr;
  logic [1:0]          mark_wdata;
  logic [AW-1:0]       mark_raddr;
  logic [1:0]          mark_rdata;

  pflms_seq #(
    .POOL_DEPTH (POOL_DEPTH)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_opcode  (s_tdata[2:0]),
    .in_slot    (s_tdata[10:3]),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res),
    .mem_ctl    (mem_ctl),
    .link_waddr (link_waddr),
    .link_wdata (link_wdata),
    .link_raddr (link_raddr),
    .link_rdata (link_rdata),
    .mark_waddr (mark_waddr),
    .mark_wdata (mark_wdata),
    .mark_raddr (mark_raddr),
    .mark_rdata (mark_rdata)
  );

  pflms_store #(
    .POOL_DEPTH (POOL_DEPTH)
  ) u_store (
    .clk        (clk),
    .mem_ctl    (mem_ctl),
    .link_waddr (link_waddr),
    .link_wdata (link_wdata),
    .link_raddr (link_raddr),
    .link_rdata (link_rdata),
    .mark_waddr (mark_waddr),
    .mark_wdata (mark_wdata),
    .mark_raddr (mark_raddr),
    .mark_rdata (mark_rdata)
  );

  // output register, loads whenever it is empty or being drained
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      m_tdata <= {4'd0, res.reclaimed_count, res.entry_status,
                  res.granted_slot, res.result_code};
    end
  end

endmodule

/* sv/pflms_checker.sv */
// ---------------------------------------------------------------------------
// pool free list port checker
// watches the stream ports of the top level over time
// ---------------------------------------------------------------------------
`include "pool_free_list_mark_sweep_top_macros.svh"

module pflms_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata
);

  logic s_take;

  assign s_take = s_tvalid && s_tready;

  // a stalled result item holds its payload
  `PFLMS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

  // one item at a time: no item is taken in the cycle after another
  `PFLMS_ASSERT_NEXT(a_one_at_a_time, s_take, !s_tready)

  // a failed alloc carries nothing but the failure flag
  `PFLMS_ASSERT_SAME(a_fail_clean, m_tvalid && m_tdata[0], m_tdata[23:1] == 23'd0)

  // a reported mark is never the unused code, and padding stays zero
  `PFLMS_ASSERT_SAME(a_mark_code, m_tvalid,
                     (m_tdata[10:9] != 2'b11) && (m_tdata[23:20] == 4'd0))

endmodule

bind pool_free_list_mark_sweep_top pflms_checker u_pflms_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
